[hw/rtl/proximity_dimmer_control_defines.svh]
// ----------------------------------------------------------------------------
// proximity dimmer control - assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_DIMMER_CONTROL_DEFINES_SVH
`define PROXIMITY_DIMMER_CONTROL_DEFINES_SVH

// same-cycle implication
`define PDC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdc assertion failed");

// next-cycle implication
`define PDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdc assertion failed");

`endif

[hw/rtl/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg
// shared constants, register indexes and controller/datapath structs
// ----------------------------------------------------------------------------
package pdc_pkg;

    // averaging ring depth
    localparam int AVERAGE_DEPTH = 5;
    localparam int DATA_W        = 16;
    localparam int THR_W         = 8;
    localparam int RING_IDX_W    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int SUM_W         = DATA_W + $clog2(AVERAGE_DEPTH);
    localparam int DIV_CNT_W     = $clog2(SUM_W + 1);
    localparam int CFG_ADDR_W    = 2;

    // ring mean by reciprocal multiply, exact over the whole sum range
    localparam int MEAN_SHIFT    = SUM_W + $clog2(AVERAGE_DEPTH);
    localparam int MEAN_RECIP    = ((1 << MEAN_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
    localparam int MEAN_RECIP_W  = SUM_W + 2;

    localparam logic [DATA_W-1:0] FULL_LEVEL = {DATA_W{1'b1}};
    localparam logic [THR_W-1:0]  COUNT_MAX  = {THR_W{1'b1}};

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_NEAR      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FAR_INIT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_JUMP      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STUCK_THR = 2'd3;

    // register reset values
    localparam logic [DATA_W-1:0] NEAR_RESET      = 16'd510;
    localparam logic [DATA_W-1:0] FAR_RESET       = 16'd1500;
    localparam logic [DATA_W-1:0] JUMP_RESET      = 16'd100;
    localparam logic [THR_W-1:0]  STUCK_THR_RESET = 8'd5;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic check_take;
        logic check_drop;
        logic sum_step;
        logic div_span;
        logic take_mean;
        logic map_direct;
        logic mul;
        logic set_target;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic func;
        logic jump_ok;
        logic sum_last;
        logic div_busy;
        logic map_direct;
        logic out_free;
    } t_status;

endpackage

[hw/rtl/pdc_divider.sv]
// ----------------------------------------------------------------------------
// pdc_divider
// restoring divider, one quotient bit per cycle, used for the brightness slope
// ----------------------------------------------------------------------------
module pdc_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pdc_pkg::SUM_W-1:0]        i_dividend,
    input  logic [pdc_pkg::DATA_W-1:0]       i_divisor,
    output logic                             o_busy,
    output logic [pdc_pkg::SUM_W-1:0]        o_quotient
);

    logic [pdc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic [pdc_pkg::SUM_W-1:0]     r_quo;
    logic [pdc_pkg::DATA_W-1:0]    r_rem;
    logic [pdc_pkg::DATA_W-1:0]    r_div;

    logic [pdc_pkg::DATA_W:0]      trial;
    logic                          fits;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_quo[pdc_pkg::SUM_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= pdc_pkg::DIV_CNT_W'(pdc_pkg::SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == pdc_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[pdc_pkg::SUM_W-2:0], fits};
            r_rem <= fits ? pdc_pkg::DATA_W'(trial - {1'b0, r_div})
                          : trial[pdc_pkg::DATA_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[hw/rtl/pdc_datapath.sv]
// ----------------------------------------------------------------------------
// pdc_datapath
// config registers, reading filter, sample ring, mapping and output slew
// ----------------------------------------------------------------------------
module pdc_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pdc_pkg::t_cmd                        i_cmd,
    output pdc_pkg::t_status                     o_status,
    input  logic                                 i_cfg_we,
    input  logic [pdc_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [pdc_pkg::DATA_W-1:0]           i_cfg_wdata,
    input  logic                                 i_func,
    input  logic [pdc_pkg::DATA_W-1:0]           i_distance,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [pdc_pkg::DATA_W-1:0]           o_level
);

    // configuration
    logic [pdc_pkg::DATA_W-1:0] r_near;
    logic [pdc_pkg::DATA_W-1:0] r_jump;
    logic [pdc_pkg::THR_W-1:0]  r_stuck_thr;

    // block state
    logic [pdc_pkg::DATA_W-1:0]     r_ring [pdc_pkg::AVERAGE_DEPTH];
    logic [pdc_pkg::RING_IDX_W-1:0] r_pos;
    logic [pdc_pkg::DATA_W-1:0]     r_last;
    logic [pdc_pkg::THR_W-1:0]      r_same;
    logic [pdc_pkg::DATA_W-1:0]     r_far;
    logic [pdc_pkg::DATA_W-1:0]     r_target;
    logic [pdc_pkg::DATA_W-1:0]     r_level;
    logic                           r_valid;

    // per-word working registers
    logic                           r_func;
    logic [pdc_pkg::DATA_W-1:0]     r_dist;
    logic [pdc_pkg::RING_IDX_W-1:0] r_sum_idx;
    logic [pdc_pkg::SUM_W-1:0]      r_sum;
    logic [pdc_pkg::DATA_W-1:0]     r_mean;
    logic [pdc_pkg::DATA_W-1:0]     r_prod;

    logic [pdc_pkg::DATA_W-1:0]     delta;
    logic [pdc_pkg::THR_W-1:0]      n_same;
    logic [pdc_pkg::RING_IDX_W-1:0] ring_last;
    logic [pdc_pkg::SUM_W+pdc_pkg::MEAN_RECIP_W-1:0] mean_prod;
    logic                           map_direct;
    logic [pdc_pkg::DATA_W-1:0]     direct_level;
    logic [2*pdc_pkg::DATA_W-1:0]   product;
    logic                           div_start;
    logic [pdc_pkg::SUM_W-1:0]      div_dividend;
    logic [pdc_pkg::DATA_W-1:0]     div_divisor;
    logic                           div_busy;
    logic [pdc_pkg::SUM_W-1:0]      div_quotient;

    assign ring_last = pdc_pkg::RING_IDX_W'(pdc_pkg::AVERAGE_DEPTH - 1);

    // jump filter and identical-reading count
    assign delta  = (r_dist > r_last) ? (r_dist - r_last) : (r_last - r_dist);
    assign n_same = (r_same < pdc_pkg::COUNT_MAX) ? (r_same + 1'b1) : r_same;

    // ring mean: sum times reciprocal of the depth
    assign mean_prod = r_sum * pdc_pkg::MEAN_RECIP_W'(pdc_pkg::MEAN_RECIP);

    // trivial mappings: below near, beyond far, zero span
    assign map_direct   = (r_mean < r_near) || (r_mean > r_far) || (r_far == r_near);
    assign direct_level = (r_mean < r_near) ? pdc_pkg::FULL_LEVEL
                        : ((r_mean > r_far) ? '0 : pdc_pkg::FULL_LEVEL);

    assign product = (r_mean - r_near) * div_quotient[pdc_pkg::DATA_W-1:0];

    // slope divider: full scale by span
    assign div_start    = i_cmd.div_span;
    assign div_dividend = pdc_pkg::SUM_W'(pdc_pkg::FULL_LEVEL);
    assign div_divisor  = r_far - r_near;

    pdc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quotient)
    );

    // configuration registers and far limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near      <= pdc_pkg::NEAR_RESET;
            r_jump      <= pdc_pkg::JUMP_RESET;
            r_stuck_thr <= pdc_pkg::STUCK_THR_RESET;
            r_far       <= pdc_pkg::FAR_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    pdc_pkg::REG_NEAR:      r_near      <= i_cfg_wdata;
                    pdc_pkg::REG_FAR_INIT:  r_far       <= i_cfg_wdata;
                    pdc_pkg::REG_JUMP:      r_jump      <= i_cfg_wdata;
                    pdc_pkg::REG_STUCK_THR: r_stuck_thr <= i_cfg_wdata[pdc_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.check_take && (r_dist == r_last) && (n_same > r_stuck_thr)) begin
                r_far <= r_dist;
            end
        end
    end

    // reading history, ring and target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pdc_pkg::AVERAGE_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_pos    <= '0;
            r_last   <= '0;
            r_same   <= '0;
            r_target <= '0;
        end else begin
            if (i_cmd.check_take) begin
                r_same        <= (r_dist == r_last) ? n_same : '0;
                r_ring[r_pos] <= r_dist;
                r_pos         <= (r_pos == ring_last) ? '0 : (r_pos + 1'b1);
            end
            if (i_cmd.check_take || i_cmd.check_drop) begin
                r_last <= r_dist;
            end
            if (i_cmd.map_direct) begin
                r_target <= direct_level;
            end else if (i_cmd.set_target) begin
                // low half of full scale minus product
                r_target <= ~r_prod;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_dist <= i_distance;
        end
        if (i_cmd.check_take) begin
            r_sum     <= '0;
            r_sum_idx <= '0;
        end else if (i_cmd.sum_step) begin
            r_sum     <= r_sum + pdc_pkg::SUM_W'(r_ring[r_sum_idx]);
            r_sum_idx <= (r_sum_idx == ring_last) ? '0 : (r_sum_idx + 1'b1);
        end
        if (i_cmd.take_mean) begin
            r_mean <= mean_prod[pdc_pkg::MEAN_SHIFT +: pdc_pkg::DATA_W];
        end
        if (i_cmd.mul) begin
            r_prod <= product[pdc_pkg::DATA_W-1:0];
        end
    end

    // output level slew and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            if (r_target > r_level) begin
                r_level <= r_level + 1'b1;
            end else if (r_target < r_level) begin
                r_level <= r_level - 1'b1;
            end
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_status.func       = r_func;
    assign o_status.jump_ok    = (delta < r_jump);
    assign o_status.sum_last   = (r_sum_idx == ring_last);
    assign o_status.div_busy   = div_busy;
    assign o_status.map_direct = map_direct;
    assign o_status.out_free   = !r_valid || i_ready;

    assign o_valid = r_valid;
    assign o_level = r_level;

endmodule

[hw/rtl/pdc_controller.sv]
// ----------------------------------------------------------------------------
// pdc_controller
// sequences one tick word through filter, sum, mean, divide and mapping
// ----------------------------------------------------------------------------
module pdc_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pdc_pkg::t_status i_status,
    output pdc_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SUM,
        S_MEAN,
        S_MAP,
        S_SPAN_WAIT,
        S_TARGET,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    // command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.func) begin
                    n_state = S_FINISH;
                end else if (i_status.jump_ok) begin
                    o_cmd.check_take = 1'b1;
                    n_state          = S_SUM;
                end else begin
                    o_cmd.check_drop = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_last) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.take_mean = 1'b1;
                n_state         = S_MAP;
            end
            S_MAP: begin
                if (i_status.map_direct) begin
                    o_cmd.map_direct = 1'b1;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.div_span = 1'b1;
                    n_state        = S_SPAN_WAIT;
                end
            end
            S_SPAN_WAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_TARGET;
                end
            end
            S_TARGET: begin
                o_cmd.set_target = 1'b1;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

[hw/rtl/proximity_dimmer_control.sv]
// ----------------------------------------------------------------------------
// proximity_dimmer_control
// distance-driven dimmer: filters readings, averages them and slews brightness
// ----------------------------------------------------------------------------
// Each input word is one control tick; tuser set means tdata carries a new
// distance reading. Every tick gives exactly one output word with the slewed
// brightness. A tick without a reading, or with a reading rejected by the jump
// filter, goes from the check straight to output. An accepted reading is
// summed over the ring and averaged, then either maps straight to full or
// zero or is scaled by the brightness slope; its duration is set by the
// ring summed one entry per cycle and, when scaled, by the one-bit-per-cycle
// divider for the slope, the mean itself being a single reciprocal multiply.
// One tick is in flight at a time; the next may be accepted while the
// previous output word still waits to be taken, and that tick then holds in
// its last cycle until the waiting word is taken.
module proximity_dimmer_control (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tick stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // [15:0] distance
    input  logic                               s_axis_tuser,  // [0] func
    // brightness stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // [15:0] brightness
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [pdc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [15:0]                        i_cfg_wdata
);

    pdc_pkg::t_cmd    cmd;
    pdc_pkg::t_status status;

    // sequencer
    pdc_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath
    pdc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_func      (s_axis_tuser),
        .i_distance  (s_axis_tdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_level     (m_axis_tdata)
    );

endmodule

[hw/rtl/pdc_checker.sv]
// ----------------------------------------------------------------------------
// pdc_checker
// port-level checks on the dimmer streams, bound to the top level
// ----------------------------------------------------------------------------
`include "proximity_dimmer_control_defines.svh"

module pdc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [15:0]                    m_axis_tdata
);

    logic        r_have;
    logic [15:0] r_last_out;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // last delivered brightness
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_last_out <= '0;
        end else if (out_acc) begin
            r_have     <= 1'b1;
            r_last_out <= m_axis_tdata;
        end
    end

    // stalled output word holds
    `PDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // one word in flight: no acceptance in the cycle after one
    `PDC_ASSERT_NEXT(a_one_in_flight, in_acc, !s_axis_tready)

    // brightness moves by at most one step per delivered word
    `PDC_ASSERT_NOW(a_slew_step, out_acc && r_have,
        (m_axis_tdata == r_last_out) || (m_axis_tdata == r_last_out + 16'd1)
            || (m_axis_tdata == r_last_out - 16'd1))

    // a fresh output word only follows an accepted tick
    `PDC_ASSERT_NEXT(a_no_spurious_out, !m_axis_tvalid && s_axis_tready && !in_acc,
        !m_axis_tvalid)

endmodule

bind proximity_dimmer_control pdc_checker u_pdc_checker (.*);
